FILE: rtl/core/fskcf_pkg.sv
// fskcf_pkg: shared types, constants and sine tables for the fsk framer
// no dependencies; used by fskcf_wave and fsk_cassette_framer_modulator
package fskcf_pkg;

  localparam int INTRO_BITS      = 8;
  localparam int OUTRO_BITS      = 8;
  localparam int COUNT_WIDTH     = 16;
  localparam int SAMPLES_PER_BIT = 10;
  localparam int SAMPLE_W        = 16;
  localparam int MARK_IDX_W      = $clog2(INTRO_BITS);
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;

  // register indexes
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_INTRO        = 2'd1;
  localparam logic [1:0] REG_OUTRO        = 2'd2;

  // register reset values
  localparam logic [COUNT_WIDTH-1:0] FRAME_LENGTH_RST = COUNT_WIDTH'(1024);
  localparam logic [INTRO_BITS-1:0]  INTRO_RST        = INTRO_BITS'(210);
  localparam logic [OUTRO_BITS-1:0]  OUTRO_RST        = OUTRO_BITS'(45);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [SAMPLES_PER_BIT-1:0] period_t;

  // which part of the frame the held item is working on
  typedef enum logic [1:0] {
    PH_INTRO,
    PH_DATA,
    PH_OUTRO
  } phase_t;

  // one full cycle over the period for a one bit
  localparam sample_t ONE_WAVE [SAMPLES_PER_BIT] = '{
    16'sd0, 16'sd19259, 16'sd31163, 16'sd31163, 16'sd19259,
    16'sd0, -16'sd19259, -16'sd31163, -16'sd31163, -16'sd19259
  };

  // half cycle over the period for a zero bit
  localparam sample_t ZERO_WAVE [SAMPLES_PER_BIT] = '{
    16'sd0, 16'sd10125, 16'sd19259, 16'sd26509, 16'sd31163,
    16'sd32767, 16'sd31163, 16'sd26509, 16'sd19259, 16'sd10125
  };

endpackage

FILE: rtl/core/fskcf_wave.sv
// fskcf_wave: builds the ten samples of one bit period with polarity applied
// depends on fskcf_pkg for the sine tables and period type
module fskcf_wave (
  input  logic              bit_val,
  input  logic              neg,
  output fskcf_pkg::period_t period
);

  // table lookup per sample, negated on negative polarity
  always_comb begin
    for (int j = 0; j < fskcf_pkg::SAMPLES_PER_BIT; j++) begin
      fskcf_pkg::sample_t v;
      v = bit_val ? fskcf_pkg::ONE_WAVE[j] : fskcf_pkg::ZERO_WAVE[j];
      period[j] = neg ? -v : v;
    end
  end

endmodule

FILE: rtl/core/fsk_cassette_framer_modulator.sv
// fsk_cassette_framer_modulator: frames payload bits with intro/outro markers
// and emits one fsk bit period per result; uses fskcf_pkg and fskcf_wave
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_ready    | in_data_bit
//  out      | out_valid / out_ready  | out_sample_0..9, out_sent_bit,
//           |                        | out_last_of_run
//  cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (pready high)
//
// one bit period is produced per cycle unless out stalls, from a one-item hold
// register into the output register: an item gives its data period, after the
// 8 intro bits at frame start and before the 8 outro bits at frame end. plain
// data items run back to back at one per cycle unless out stalls; the next item
// is taken in the cycle the last period of the held item is loaded. synchronous
// active-low reset restores the registers and clears polarity, bit count and
// valid flags. a stall on out holds the output register and the held item.
module fsk_cassette_framer_modulator (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_data_bit,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_0,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_1,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_2,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_3,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_4,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_5,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_6,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_7,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_8,
  output logic signed [fskcf_pkg::SAMPLE_W-1:0] out_sample_9,
  output logic                              out_sent_bit,
  output logic                              out_last_of_run,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fskcf_pkg::PADDR_W-1:0]     paddr,
  input  logic [fskcf_pkg::PDATA_W-1:0]     pwdata,
  output logic [fskcf_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  // configuration registers
  logic [fskcf_pkg::COUNT_WIDTH-1:0] frame_len_r;
  logic [fskcf_pkg::INTRO_BITS-1:0]  intro_r;
  logic [fskcf_pkg::OUTRO_BITS-1:0]  outro_r;

  // held item and sequencer state
  logic                              item_valid_r, item_valid_nxt;
  logic                              item_bit_r, item_bit_nxt;
  fskcf_pkg::phase_t                 phase_r, phase_nxt;
  logic [fskcf_pkg::MARK_IDX_W-1:0]  idx_r, idx_nxt;
  logic                              tone_sign_r, tone_sign_nxt;
  logic [fskcf_pkg::COUNT_WIDTH-1:0] bit_pos_r, bit_pos_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  fskcf_pkg::period_t                out_period_r;
  logic                              out_bit_r;
  logic                              out_last_r;

  logic                              gen;
  logic                              cur_bit;
  logic                              cur_last;
  logic [fskcf_pkg::COUNT_WIDTH-1:0] pos_inc;
  logic                              frame_end;
  logic                              wr_en;
  fskcf_pkg::period_t                period;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= fskcf_pkg::FRAME_LENGTH_RST;
      intro_r     <= fskcf_pkg::INTRO_RST;
      outro_r     <= fskcf_pkg::OUTRO_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        fskcf_pkg::REG_FRAME_LENGTH: frame_len_r <= pwdata[fskcf_pkg::COUNT_WIDTH-1:0];
        fskcf_pkg::REG_INTRO:        intro_r     <= pwdata[fskcf_pkg::INTRO_BITS-1:0];
        fskcf_pkg::REG_OUTRO:        outro_r     <= pwdata[fskcf_pkg::OUTRO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      fskcf_pkg::REG_FRAME_LENGTH:
        prdata = {{(fskcf_pkg::PDATA_W-fskcf_pkg::COUNT_WIDTH){1'b0}}, frame_len_r};
      fskcf_pkg::REG_INTRO:
        prdata = {{(fskcf_pkg::PDATA_W-fskcf_pkg::INTRO_BITS){1'b0}}, intro_r};
      fskcf_pkg::REG_OUTRO:
        prdata = {{(fskcf_pkg::PDATA_W-fskcf_pkg::OUTRO_BITS){1'b0}}, outro_r};
      default:
        prdata = '0;
    endcase
  end

  // current period: bit, end-of-item flag and frame sequencing
  always_comb begin
    gen       = item_valid_r && (!out_valid_r || out_ready);
    pos_inc   = bit_pos_r + fskcf_pkg::COUNT_WIDTH'(1);
    frame_end = (pos_inc == frame_len_r);
    cur_bit   = item_bit_r;
    cur_last  = 1'b0;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    bit_pos_nxt = bit_pos_r;

    case (phase_r)
      fskcf_pkg::PH_INTRO: begin
        cur_bit = intro_r[fskcf_pkg::MARK_IDX_W'(fskcf_pkg::INTRO_BITS-1) - idx_r];
        if (gen) begin
          idx_nxt = idx_r + fskcf_pkg::MARK_IDX_W'(1);
          if (idx_r == fskcf_pkg::MARK_IDX_W'(fskcf_pkg::INTRO_BITS-1)) begin
            phase_nxt = fskcf_pkg::PH_DATA;
          end
        end
      end
      fskcf_pkg::PH_DATA: begin
        cur_bit  = item_bit_r;
        cur_last = !frame_end;
        if (gen) begin
          if (frame_end) begin
            bit_pos_nxt = '0;
            phase_nxt   = fskcf_pkg::PH_OUTRO;
            idx_nxt     = '0;
          end else begin
            bit_pos_nxt = pos_inc;
          end
        end
      end
      fskcf_pkg::PH_OUTRO: begin
        cur_bit  = outro_r[fskcf_pkg::MARK_IDX_W'(fskcf_pkg::OUTRO_BITS-1) - idx_r];
        cur_last = (idx_r == fskcf_pkg::MARK_IDX_W'(fskcf_pkg::OUTRO_BITS-1));
        if (gen) begin
          idx_nxt = idx_r + fskcf_pkg::MARK_IDX_W'(1);
        end
      end
      default: begin
        cur_bit  = item_bit_r;
        cur_last = 1'b1;
      end
    endcase

    // polarity flips after every zero bit sent
    tone_sign_nxt = (gen && !cur_bit) ? !tone_sign_r : tone_sign_r;

    // hold register: free when the last period leaves, refilled on accept
    in_ready       = !item_valid_r || (gen && cur_last);
    item_valid_nxt = item_valid_r;
    item_bit_nxt   = item_bit_r;
    if (gen && cur_last) begin
      item_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      item_valid_nxt = 1'b1;
      item_bit_nxt   = in_data_bit;
      idx_nxt        = '0;
      phase_nxt      = (bit_pos_nxt == '0) ? fskcf_pkg::PH_INTRO : fskcf_pkg::PH_DATA;
    end

    // output register occupancy
    if (gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  fskcf_wave u_wave (
    .bit_val (cur_bit),
    .neg     (tone_sign_r),
    .period  (period)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      tone_sign_r  <= 1'b0;
      bit_pos_r    <= '0;
      phase_r      <= fskcf_pkg::PH_INTRO;
      idx_r        <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      tone_sign_r  <= tone_sign_nxt;
      bit_pos_r    <= bit_pos_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_bit_r <= item_bit_nxt;
    if (gen) begin
      out_period_r <= period;
      out_bit_r    <= cur_bit;
      out_last_r   <= cur_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_0    = out_period_r[0];
  assign out_sample_1    = out_period_r[1];
  assign out_sample_2    = out_period_r[2];
  assign out_sample_3    = out_period_r[3];
  assign out_sample_4    = out_period_r[4];
  assign out_sample_5    = out_period_r[5];
  assign out_sample_6    = out_period_r[6];
  assign out_sample_7    = out_period_r[7];
  assign out_sample_8    = out_period_r[8];
  assign out_sample_9    = out_period_r[9];
  assign out_sent_bit    = out_bit_r;
  assign out_last_of_run = out_last_r;

endmodule
